@@ sv/palette_rle_sprite_row_decoder_defines.svh @@
// Assertion helpers used by the emitter module.
`ifndef PALETTE_RLE_SPRITE_ROW_DECODER_DEFINES_SVH
`define PALETTE_RLE_SPRITE_ROW_DECODER_DEFINES_SVH

// Condition holds in the same cycle as the trigger.
`define PRSD_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Condition holds in the cycle after the trigger.
`define PRSD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/prsd_pkg.sv @@
package prsd_pkg;

    typedef enum logic [1:0] {
        OP_BASE_WR   = 2'd0,
        OP_PLAYER_WR = 2'd1,
        OP_ROW_DATA  = 2'd2,
        OP_BOTH_WR   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        MODE_CONTROL = 2'd0,
        MODE_SOLID   = 2'd1,
        MODE_LITERAL = 2'd2
    } t_mode;

    typedef enum logic [1:0] {
        TAIL_NONE    = 2'd0,
        TAIL_RUN_ERR = 2'd1,
        TAIL_TRUNC   = 2'd2
    } t_tail;

    typedef enum logic [1:0] {
        SRC_BASE   = 2'd0,
        SRC_PLAYER = 2'd1,
        SRC_BLACK  = 2'd2
    } t_src;

    localparam logic [1:0] ST_PIXEL   = 2'd0;
    localparam logic [1:0] ST_RUN_ERR = 2'd1;
    localparam logic [1:0] ST_TRUNC   = 2'd2;

    localparam logic REG_ROW_WIDTH = 1'b0;
    localparam logic REG_PLAYER_EN = 1'b1;

    localparam logic [7:0] ROW_WIDTH_RST = 8'hFF;

    // One decoded byte's worth of output work.
    typedef struct packed {
        logic       vld;
        logic [5:0] npix;
        logic [7:0] x;
        t_tail      tail;
        logic [7:0] tail_x;
    } t_job;

endpackage

@@ sv/prsd_palette.sv @@
module prsd_palette
    import prsd_pkg::*;
#(
    parameter int PALETTE_ENTRIES = 256,
    parameter int PLAYER_COLORS   = 8
) (
    input  logic        i_clk,
    input  logic        i_wr_base,
    input  logic        i_wr_player,
    input  logic [7:0]  i_wr_index,
    input  logic [23:0] i_wr_color,
    input  logic        i_rd_en,
    input  logic [7:0]  i_rd_index,
    input  logic        i_player_en,
    output logic [23:0] o_color
);

    localparam int BaseAw   = $clog2(PALETTE_ENTRIES);
    localparam int PlayerAw = (PLAYER_COLORS > 1) ? $clog2(PLAYER_COLORS) : 1;

    logic [23:0] r_base   [PALETTE_ENTRIES];
    logic [23:0] r_player [PLAYER_COLORS];
    logic [23:0] r_base_q;
    logic [23:0] r_player_q;
    t_src        r_src;
    t_src        n_src;
    logic        wr_base_ok;
    logic        wr_player_ok;
    logic        rd_base_ok;
    logic        rd_player_ok;

    assign wr_base_ok   = {1'b0, i_wr_index} < 9'(PALETTE_ENTRIES);
    assign wr_player_ok = {1'b0, i_wr_index} < 9'(PLAYER_COLORS);
    assign rd_base_ok   = {1'b0, i_rd_index} < 9'(PALETTE_ENTRIES);
    // indices 8..15 map onto player slots 0..7
    assign rd_player_ok = i_player_en && (i_rd_index[7:3] == 5'd1) &&
                          ({1'b0, i_rd_index[2:0]} < 4'(PLAYER_COLORS));

    always_comb begin
        if (rd_player_ok) begin
            n_src = SRC_PLAYER;
        end else if (rd_base_ok) begin
            n_src = SRC_BASE;
        end else begin
            n_src = SRC_BLACK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_base && wr_base_ok) begin
            r_base[i_wr_index[BaseAw-1:0]] <= i_wr_color;
        end
        if (i_rd_en) begin
            r_base_q <= r_base[i_rd_index[BaseAw-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_player && wr_player_ok) begin
            r_player[i_wr_index[PlayerAw-1:0]] <= i_wr_color;
        end
        if (i_rd_en) begin
            r_player_q <= r_player[i_rd_index[PlayerAw-1:0]];
            r_src      <= n_src;
        end
    end

    always_comb begin
        unique case (r_src)
            SRC_PLAYER: o_color = r_player_q;
            SRC_BASE:   o_color = r_base_q;
            default:    o_color = 24'd0;
        endcase
    end

endmodule

@@ sv/prsd_row_parser.sv @@
module prsd_row_parser
    import prsd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_item,
    input  logic [7:0] i_byte,
    input  logic       i_row_first,
    input  logic       i_row_last,
    input  logic [7:0] i_row_width,
    output logic       o_rd_en,
    output t_job       o_job
);

    t_mode      r_mode;
    t_mode      n_mode;
    logic [7:0] r_col;
    logic [7:0] n_col;
    logic [5:0] r_rem;
    logic [5:0] n_rem;
    logic       r_stop;
    logic       n_stop;

    t_mode      mode0;
    logic [7:0] col0;
    logic [5:0] rem0;
    logic       stop0;
    logic       active;
    logic       transparent;
    logic [6:0] len;
    logic [7:0] room;
    logic       bad;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_CONTROL;
            r_col  <= 8'd0;
            r_rem  <= 6'd0;
            r_stop <= 1'b0;
        end else begin
            r_mode <= n_mode;
            r_col  <= n_col;
            r_rem  <= n_rem;
            r_stop <= n_stop;
        end
    end

    always_comb begin
        mode0 = i_row_first ? MODE_CONTROL : r_mode;
        col0  = i_row_first ? 8'd0 : r_col;
        rem0  = i_row_first ? 6'd0 : r_rem;
        stop0 = i_row_first ? 1'b0 : r_stop;

        active      = !stop0 && (col0 < i_row_width);
        transparent = i_byte[7];
        len         = transparent ? i_byte[6:0] : {1'b0, i_byte[5:0]};
        room        = i_row_width - col0;
        bad         = (len == 7'd0) || ({1'b0, len} > room);

        n_mode = r_mode;
        n_col  = r_col;
        n_rem  = r_rem;
        n_stop = r_stop;
        o_rd_en = 1'b0;
        o_job   = '{vld: 1'b0, npix: 6'd0, x: col0, tail: TAIL_NONE, tail_x: col0};

        if (i_item) begin
            n_mode = mode0;
            n_col  = col0;
            n_rem  = rem0;
            n_stop = stop0;
            if (active) begin
                unique case (mode0)
                    MODE_CONTROL: begin
                        if (bad) begin
                            o_job.tail = TAIL_RUN_ERR;
                            n_stop     = 1'b1;
                        end else if (transparent) begin
                            n_col = col0 + {1'b0, len};
                        end else begin
                            n_rem  = len[5:0];
                            n_mode = i_byte[6] ? MODE_SOLID : MODE_LITERAL;
                        end
                    end
                    MODE_SOLID: begin
                        o_rd_en    = 1'b1;
                        o_job.npix = rem0;
                        n_col      = col0 + {2'b00, rem0};
                        n_rem      = 6'd0;
                        n_mode     = MODE_CONTROL;
                    end
                    MODE_LITERAL: begin
                        o_rd_en    = 1'b1;
                        o_job.npix = 6'd1;
                        n_col      = col0 + 8'd1;
                        n_rem      = rem0 - 6'd1;
                        if (n_rem == 6'd0) begin
                            n_mode = MODE_CONTROL;
                        end
                    end
                    default: begin
                        n_mode = MODE_CONTROL;
                    end
                endcase
                // end of row: complete rows never report truncation
                if (!(mode0 == MODE_CONTROL && bad)) begin
                    if (n_col >= i_row_width) begin
                        n_stop = 1'b1;
                    end else if (i_row_last) begin
                        o_job.tail   = TAIL_TRUNC;
                        o_job.tail_x = n_col;
                        n_stop       = 1'b1;
                    end
                end
                o_job.vld = (o_job.npix != 6'd0) || (o_job.tail != TAIL_NONE);
            end
        end
    end

endmodule

@@ sv/prsd_emitter.sv @@
`include "palette_rle_sprite_row_decoder_defines.svh"

module prsd_emitter
    import prsd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_job        i_job,
    input  logic [23:0] i_color,
    output logic        o_busy,
    output logic        o_tvalid,
    input  logic        i_tready,
    output logic [31:0] o_tdata,   // pixel_x, red, green, blue
    output logic [1:0]  o_tuser,   // status
    output logic        o_tlast
);

    logic        r_job_vld;
    logic [5:0]  r_left;
    logic [7:0]  r_x;
    t_tail       r_tail;
    logic [7:0]  r_tail_x;
    logic        r_out_vld;
    logic [31:0] r_out_data;
    logic [1:0]  r_out_status;
    logic        r_out_last;

    logic        slot_free;
    logic        step;
    logic        final_res;
    logic        done;

    assign slot_free = !r_out_vld || i_tready;
    assign step      = r_job_vld && slot_free;
    assign final_res = (r_left != 6'd0) ? ((r_left == 6'd1) && (r_tail == TAIL_NONE)) : 1'b1;
    assign done      = step && final_res;
    // input may be taken while the last result of the current job goes out
    assign o_busy    = r_job_vld && !done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_job_vld <= 1'b0;
        end else if (i_job.vld) begin
            r_job_vld <= 1'b1;
        end else if (done) begin
            r_job_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_job.vld) begin
            r_left   <= i_job.npix;
            r_x      <= i_job.x;
            r_tail   <= i_job.tail;
            r_tail_x <= i_job.tail_x;
        end else if (step && (r_left != 6'd0)) begin
            r_left <= r_left - 6'd1;
            r_x    <= r_x + 8'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (step) begin
            r_out_vld <= 1'b1;
        end else if (i_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out_last <= final_res;
            if (r_left != 6'd0) begin
                r_out_data   <= {i_color[7:0], i_color[15:8], i_color[23:16], r_x};
                r_out_status <= ST_PIXEL;
            end else begin
                r_out_data   <= {24'd0, r_tail_x};
                r_out_status <= (r_tail == TAIL_RUN_ERR) ? ST_RUN_ERR : ST_TRUNC;
            end
        end
    end

    assign o_tvalid = r_out_vld;
    assign o_tdata  = r_out_data;
    assign o_tuser  = r_out_status;
    assign o_tlast  = r_out_last;

    `PRSD_ASSERT_NOW(a_job_not_empty, i_clk, i_rst_n, r_job_vld, (r_left != 6'd0) || (r_tail != TAIL_NONE), "pending job holds no work")
    `PRSD_ASSERT_NOW(a_no_job_overwrite, i_clk, i_rst_n, i_job.vld, !r_job_vld || done, "new job while previous one still emitting")
    `PRSD_ASSERT_NOW(a_error_is_last, i_clk, i_rst_n, o_tvalid && (o_tuser != ST_PIXEL), o_tlast, "error result not marked last")
    `PRSD_ASSERT_NEXT(a_done_clears, i_clk, i_rst_n, done && !i_job.vld, !r_job_vld, "job still pending after final result")

endmodule

@@ sv/palette_rle_sprite_row_decoder.sv @@
// Palette run-length sprite row decoder.
// Input stream: one item per encoded byte or palette write. tuser[1:0] is the op
// (base write, player write, row byte, both writes), tuser[2] marks the first
// byte of a row, tlast the last available byte of the row.
// Output stream: one item per pixel or error, tuser carries the status, tlast
// marks the final result caused by one input item.
// APB port: register 0 frame width at 0x0, register 1 player palette enable at
// 0x4; the user must write them only while the decoder is idle, and the block
// does not enforce this. A row byte's first result passes the palette read and
// job register, both loaded when the byte is accepted, then the output register.
// Throughput: palette writes, control bytes and literal bytes 1 item/cycle while
// the output is not stalled; a solid run holds the input until its last pixel
// is emitted, and a truncation result holds it as well. The emitter drains one
// result per cycle from a single job register while the receiver is ready,
// which is what holds the input during a run.
// Reset clears the row state, frame width to 255 and player palette off;
// palette memories hold garbage until written. When the receiver stalls, the
// output register holds its item and the input is held once a job is pending.
module palette_rle_sprite_row_decoder
    import prsd_pkg::*;
#(
    parameter int PALETTE_ENTRIES = 256,
    parameter int PLAYER_COLORS   = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,  // table_index, color_word, data_byte
    input  logic [2:0]  s_axis_tuser,  // op, row_first
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,  // pixel_x, red, green, blue
    output logic [1:0]  m_axis_tuser,  // status
    output logic        m_axis_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [7:0] r_row_width;
    logic       r_player_en;
    logic       cfg_wr;
    logic       accept;
    t_op        op;
    logic       item;
    logic       rd_en;
    t_job       job;
    logic       busy;
    logic [23:0] color;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_width <= ROW_WIDTH_RST;
            r_player_en <= 1'b0;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                REG_ROW_WIDTH: r_row_width <= pwdata[7:0];
                REG_PLAYER_EN: r_player_en <= pwdata[0];
                default:       r_player_en <= r_player_en;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_ROW_WIDTH: prdata = {24'd0, r_row_width};
            REG_PLAYER_EN: prdata = {31'd0, r_player_en};
            default:       prdata = 32'd0;
        endcase
    end

    assign s_axis_tready = !busy;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign op            = t_op'(s_axis_tuser[1:0]);
    assign item          = accept && (op == OP_ROW_DATA);

    prsd_palette #(
        .PALETTE_ENTRIES(PALETTE_ENTRIES),
        .PLAYER_COLORS  (PLAYER_COLORS)
    ) u_palette (
        .i_clk      (i_clk),
        .i_wr_base  (accept && (op == OP_BASE_WR || op == OP_BOTH_WR)),
        .i_wr_player(accept && (op == OP_PLAYER_WR || op == OP_BOTH_WR)),
        .i_wr_index (s_axis_tdata[7:0]),
        .i_wr_color (s_axis_tdata[31:8]),
        .i_rd_en    (rd_en),
        .i_rd_index (s_axis_tdata[39:32]),
        .i_player_en(r_player_en),
        .o_color    (color)
    );

    prsd_row_parser u_parser (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_item     (item),
        .i_byte     (s_axis_tdata[39:32]),
        .i_row_first(s_axis_tuser[2]),
        .i_row_last (s_axis_tlast),
        .i_row_width(r_row_width),
        .o_rd_en    (rd_en),
        .o_job      (job)
    );

    prsd_emitter u_emitter (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_job   (job),
        .i_color (color),
        .o_busy  (busy),
        .o_tvalid(m_axis_tvalid),
        .i_tready(m_axis_tready),
        .o_tdata (m_axis_tdata),
        .o_tuser (m_axis_tuser),
        .o_tlast (m_axis_tlast)
    );

endmodule
